>>> design/rsmb_pkg.sv
// Package for the meeting room scheduler: field widths, saturation limits and the
// command and status groups between the controller and the datapath.
// Depends on nothing; every other design file uses it.
package rsmb_pkg;

    localparam int TIME_W          = 32;
    localparam int END_W           = 40;
    localparam int CNT_W           = 32;
    localparam int ROOM_W          = 4;
    localparam int ROOM_COUNT_W    = 5;
    localparam int MAX_ROOMS_DFLT  = 16;

    localparam logic [ROOM_COUNT_W-1:0] ROOM_COUNT_RESET = 5'd16;
    localparam logic [END_W-1:0]        END_MAX          = {END_W{1'b1}};
    localparam logic [CNT_W-1:0]        CNT_MAX          = {CNT_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch a request and restart the room scan
        logic issue;   // read the next room entry
        logic update;  // write back the chosen room and maybe the result
    } rsmb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done; // the room being read is the last one in use
        logic out_full;  // the result register still holds an untaken result
        logic last;      // the held request closes the job
    } rsmb_status_t;

endpackage

>>> design/rsmb_if.sv
// Valid/ready channel interfaces for meeting requests and for results.
// Depends on rsmb_pkg for the field widths.
interface rsmb_req_if;
    logic                         valid;
    logic                         ready;
    logic [rsmb_pkg::TIME_W-1:0]  start_time;
    logic [rsmb_pkg::TIME_W-1:0]  end_time;
    logic                         last;

    modport source (output valid, output start_time, output end_time, output last,
                    input ready);
    modport sink   (input valid, input start_time, input end_time, input last,
                    output ready);
endinterface

interface rsmb_res_if;
    logic                         valid;
    logic                         ready;
    logic [rsmb_pkg::ROOM_W-1:0]  most_booked_room;

    modport source (output valid, output most_booked_room, input ready);
    modport sink   (input valid, input most_booked_room, output ready);
endinterface

>>> design/rsmb_ctrl.sv
// Sequencing controller for the room scheduler: accept, scan, drain, update.
// Depends on rsmb_pkg for the command and status groups.
module rsmb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rsmb_pkg::rsmb_status_t status,
    output rsmb_pkg::rsmb_cmd_t   cmd
);
    import rsmb_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   accept;

    assign accept   = in_valid && in_ready_reg;
    assign in_ready = in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.scan_done)
                begin
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                state_next = UPDATE;
            end
            UPDATE:
            begin
                // A closing request waits until the previous result is taken.
                if (!(status.last && status.out_full))
                begin
                    cmd.update = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
        in_ready_next = (state_next == IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    // Only one request is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready_reg)
        else $error("request accepted while another is in work");

    // A write-back is always followed by readiness for the next request.
    a_ready_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> in_ready_reg)
        else $error("not ready after write-back");

    // A request is only latched while the block is offering readiness.
    a_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> in_ready_reg)
        else $error("request latched while busy");

endmodule

>>> design/rsmb_dp.sv
// Datapath of the room scheduler: room end and booking memories, the scan
// accumulators, the write-back arithmetic and the result register.
// Depends on rsmb_pkg for widths, limits and the command and status groups.
module rsmb_dp #(
    parameter int MAX_ROOMS = rsmb_pkg::MAX_ROOMS_DFLT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rsmb_pkg::ROOM_COUNT_W-1:0] cfg_wdata,
    input  logic [rsmb_pkg::TIME_W-1:0]       start_time,
    input  logic [rsmb_pkg::TIME_W-1:0]       end_time,
    input  logic                              last,
    input  rsmb_pkg::rsmb_cmd_t               cmd,
    output rsmb_pkg::rsmb_status_t            status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rsmb_pkg::ROOM_W-1:0]       most_booked_room
);
    import rsmb_pkg::*;

    localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam logic [7:0] MAX_ROOMS_8 = 8'(MAX_ROOMS);

    // Configuration and request holding registers.
    logic [ROOM_COUNT_W-1:0] room_count_reg;
    logic [TIME_W-1:0]       start_reg;
    logic [TIME_W-1:0]       end_reg;
    logic                    last_reg;
    logic [IDX_W-1:0]        n_last_reg;
    logic [IDX_W-1:0]        n_last_next;

    // Scan address and read pipeline.
    logic [IDX_W-1:0]        scan_idx_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    rd_vld_reg;
    logic [END_W-1:0]        end_rd_reg;
    logic [CNT_W-1:0]        cnt_rd_reg;
    logic                    entry_vld_rd_reg;

    // Storage; an entry whose valid bit is clear reads as zero.
    logic [END_W-1:0]        end_mem [MAX_ROOMS];
    logic [CNT_W-1:0]        cnt_mem [MAX_ROOMS];
    logic [MAX_ROOMS-1:0]    entry_vld_reg;

    // Scan accumulators.
    logic                    found_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    logic [CNT_W-1:0]        free_cnt_reg;
    logic [END_W-1:0]        min_end_reg;
    logic [IDX_W-1:0]        min_idx_reg;
    logic [CNT_W-1:0]        min_cnt_reg;
    logic [CNT_W-1:0]        best_cnt_reg;
    logic [IDX_W-1:0]        best_idx_reg;

    // Result register.
    logic                    out_valid_reg;
    logic [ROOM_W-1:0]       out_room_reg;

    // Combinational values.
    logic [7:0]              rc_8;
    logic [7:0]              n_use_8;
    logic [7:0]              n_use_m1_8;
    logic [END_W-1:0]        e_eff;
    logic [CNT_W-1:0]        c_eff;
    logic                    first_rd;
    logic [END_W-1:0]        start_ext;
    logic [IDX_W-1:0]        pick;
    logic [CNT_W-1:0]        old_cnt;
    logic [CNT_W-1:0]        new_cnt;
    logic [TIME_W-1:0]       dur;
    logic [END_W:0]          delay_sum;
    logic [END_W-1:0]        new_end;
    logic [IDX_W-1:0]        res_idx;

    // Rooms in use: zero counts as one, anything above the array size saturates.
    always_comb
    begin
        rc_8 = {3'b000, room_count_reg};
        if (rc_8 == 8'd0)
        begin
            n_use_8 = 8'd1;
        end
        else if (rc_8 > MAX_ROOMS_8)
        begin
            n_use_8 = MAX_ROOMS_8;
        end
        else
        begin
            n_use_8 = rc_8;
        end
        n_use_m1_8  = n_use_8 - 8'd1;
        n_last_next = n_use_m1_8[IDX_W-1:0];
    end

    assign e_eff     = entry_vld_rd_reg ? end_rd_reg : '0;
    assign c_eff     = entry_vld_rd_reg ? cnt_rd_reg : '0;
    assign first_rd  = (rd_idx_reg == '0);
    assign start_ext = {{(END_W-TIME_W){1'b0}}, start_reg};

    // Write-back: a free room ends at the request's end, otherwise the earliest
    // ending room is pushed back by the meeting's length, saturating.
    always_comb
    begin
        pick      = found_reg ? free_idx_reg : min_idx_reg;
        old_cnt   = found_reg ? free_cnt_reg : min_cnt_reg;
        new_cnt   = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;
        dur       = (end_reg > start_reg) ? end_reg - start_reg : '0;
        delay_sum = {1'b0, min_end_reg} + {{(END_W+1-TIME_W){1'b0}}, dur};
        if (found_reg)
        begin
            new_end = {{(END_W-TIME_W){1'b0}}, end_reg};
        end
        else if (delay_sum[END_W])
        begin
            new_end = END_MAX;
        end
        else
        begin
            new_end = delay_sum[END_W-1:0];
        end
        // Only the picked room's count changed, so compare it with the old leader.
        if ((new_cnt > best_cnt_reg) || ((new_cnt == best_cnt_reg) && (pick < best_idx_reg)))
        begin
            res_idx = pick;
        end
        else
        begin
            res_idx = best_idx_reg;
        end
    end

    // Memories: read at the scan address, written at write-back.
    always_ff @(posedge clk)
    begin
        end_rd_reg <= end_mem[scan_idx_reg];
        cnt_rd_reg <= cnt_mem[scan_idx_reg];
        if (cmd.update)
        begin
            end_mem[pick] <= new_end;
            cnt_mem[pick] <= new_cnt;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg  <= start_time;
            end_reg    <= end_time;
            n_last_reg <= n_last_next;
        end
        entry_vld_rd_reg <= entry_vld_reg[scan_idx_reg];
        rd_idx_reg       <= scan_idx_reg;
        if (rd_vld_reg)
        begin
            if (first_rd || (!found_reg && (e_eff <= start_ext)))
            begin
                free_idx_reg <= rd_idx_reg;
                free_cnt_reg <= c_eff;
            end
            if (first_rd || (e_eff < min_end_reg))
            begin
                min_end_reg <= e_eff;
                min_idx_reg <= rd_idx_reg;
                min_cnt_reg <= c_eff;
            end
            if (first_rd || (c_eff > best_cnt_reg))
            begin
                best_cnt_reg <= c_eff;
                best_idx_reg <= rd_idx_reg;
            end
        end
        if (cmd.update && last_reg)
        begin
            out_room_reg <= ROOM_W'(res_idx);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_count_reg <= ROOM_COUNT_RESET;
            last_reg       <= 1'b0;
            scan_idx_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            found_reg      <= 1'b0;
            entry_vld_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                room_count_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                last_reg     <= last;
                scan_idx_reg <= '0;
            end
            else if (cmd.issue && (scan_idx_reg != n_last_reg))
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            rd_vld_reg <= cmd.issue;
            if (rd_vld_reg)
            begin
                found_reg <= (first_rd ? 1'b0 : found_reg) || (e_eff <= start_ext);
            end
            if (cmd.update)
            begin
                if (last_reg)
                begin
                    // Closing request: every room entry is marked invalid and reads as zero again.
                    entry_vld_reg <= '0;
                end
                else
                begin
                    entry_vld_reg[pick] <= 1'b1;
                end
            end
            if (cmd.update && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.scan_done  = (scan_idx_reg == n_last_reg);
    assign status.out_full   = out_valid_reg;
    assign status.last       = last_reg;
    assign out_valid         = out_valid_reg;
    assign most_booked_room  = out_room_reg;

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && last_reg) |-> !out_valid_reg)
        else $error("result register overwritten");

    // Closing a job leaves every room entry reading as zero.
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && last_reg) |=> (entry_vld_reg == '0))
        else $error("job state not cleared");

    // The scan never reads beyond the rooms in use.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (rd_idx_reg <= n_last_reg))
        else $error("room scan out of range");

endmodule

>>> design/room_scheduler_most_booked_unit.sv
// Top level of the meeting room scheduler that reports the most booked room.
// Depends on rsmb_pkg, rsmb_if, rsmb_ctrl and rsmb_dp.
//
//  Channel  Direction  Carries                              Transfer when
//  req      in         start_time, end_time, last           req.valid && req.ready
//  res      out        most_booked_room                     res.valid && res.ready
//  cfg      in         cfg_wdata (room_count, 5 bits)       cfg_we
//
// Each accepted request scans the N rooms in use, one room entry a cycle, from
// the end time and booking memories; a drain step then empties the read register,
// and a write-back step writes the chosen room back before the block is ready
// again. Reset empties every room at once by clearing the per-room valid bits;
// no clearing pass is needed. A closing request whose result would meet an
// untaken result holds in its write-back state until the result register is
// free; ordinary requests never stall.
module room_scheduler_most_booked_unit #(
    parameter int MAX_ROOMS = rsmb_pkg::MAX_ROOMS_DFLT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rsmb_pkg::ROOM_COUNT_W-1:0] cfg_wdata,
    rsmb_req_if.sink                          req,
    rsmb_res_if.source                        res
);
    import rsmb_pkg::*;

    rsmb_cmd_t    cmd;
    rsmb_status_t status;

    // The controller sequences one request at a time through the scan.
    rsmb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the rooms, the running choices and the result register,
    // which parts the result side from the request side.
    rsmb_dp #(
        .MAX_ROOMS (MAX_ROOMS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .start_time       (req.start_time),
        .end_time         (req.end_time),
        .last             (req.last),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (res.valid),
        .out_ready        (res.ready),
        .most_booked_room (res.most_booked_room)
    );

endmodule

>>> test/tb_room_scheduler_most_booked_unit.sv
// Self-checking testbench for the meeting room scheduler that reports the most booked room.
// Uses rsmb_pkg, the rsmb_req_if/rsmb_res_if channel interfaces and the unit itself;
// a directed table runs first, then random jobs scored against a behavioural predictor.
module tb_room_scheduler_most_booked_unit;
    import rsmb_pkg::*;

    // Run-length and pacing constants.
    localparam int ITEM_TARGET  = 1150;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int MAX_ROOMS    = MAX_ROOMS_DFLT;
    // A request occupies the block while it scans the rooms in use; this margin comfortably
    // covers the largest room count plus the drain, the write-back and the result register.
    localparam int DRAIN_CYCLES = 2 * MAX_ROOMS + 8;
    // Length of the deliberate receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES  = 600;

    // One row of the directed table. When cfg_set is high the room count is
    // rewritten, with the block idle, before the request is offered. When
    // known_res is high the expected room is typed in the row; otherwise the
    // predictor supplies it.
    typedef struct packed {
        logic                    cfg_set;
        logic [ROOM_COUNT_W-1:0] cfg_val;
        logic [TIME_W-1:0]       start_time;
        logic [TIME_W-1:0]       end_time;
        logic                    last;
        logic                    known_res;
        logic [ROOM_W-1:0]       room;
    } plan_row_t;

    localparam int PLAN_LEN = 24;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // Reset room count: a lone booking always lands in room 0.
        '{1'b0, 5'd0,  32'd0,          32'd10,         1'b1, 1'b1, 4'd0},
        // Extreme start with an end that is not after it.
        '{1'b0, 5'd0,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 1'b1, 4'd0},
        // Longest meetings fill rooms 0 and 1, then a short one takes room 2.
        '{1'b0, 5'd0,  32'd0,          32'hFFFF_FFFF,  1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd0,          32'hFFFF_FFFF,  1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd5,          32'd6,          1'b0, 1'b0, 4'd0},
        // Room 0 is free again exactly at its end time; end before start.
        '{1'b0, 5'd0,  32'hFFFF_FFFF,  32'd0,          1'b1, 1'b0, 4'd0},
        // A single room: the second meeting is delayed onto it.
        '{1'b1, 5'd1,  32'd0,          32'd5,          1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd0,          32'd7,          1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd3,          32'd2,          1'b1, 1'b1, 4'd0},
        // A room count of zero behaves as one room; zero-length meetings.
        '{1'b1, 5'd0,  32'd0,          32'd0,          1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd0,          32'd0,          1'b1, 1'b1, 4'd0},
        // A room count above the maximum saturates; counts tie between rooms 0 and 1.
        '{1'b1, 5'd31, 32'd0,          32'd100,        1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd0,          32'd100,        1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd0,          32'd100,        1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd100,        32'd150,        1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd100,        32'd150,        1'b1, 1'b0, 4'd0},
        // Three rooms with ties on the earliest end, then a count change mid-job
        // leaves room 1, the busiest, out of the result.
        '{1'b1, 5'd3,  32'd0,          32'd10,         1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd0,          32'd10,         1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd0,          32'd20,         1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd5,          32'd25,         1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd5,          32'd9,          1'b0, 1'b0, 4'd0},
        '{1'b0, 5'd0,  32'd5,          32'd9,          1'b0, 1'b0, 4'd0},
        '{1'b1, 5'd1,  32'd40,         32'd50,         1'b1, 1'b0, 4'd0},
        // Back to the full set of rooms: fresh job, single booking.
        '{1'b1, 5'd16, 32'd7,          32'd8,          1'b1, 1'b1, 4'd0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [ROOM_COUNT_W-1:0] cfg_wdata;

    rsmb_req_if req_ch ();
    rsmb_res_if res_ch ();

    room_scheduler_most_booked_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state: when each room next becomes free, how often it has been
    // booked in the current job, and the room count as last written.
    logic [END_W-1:0]        room_free_at [MAX_ROOMS];
    logic [CNT_W-1:0]        room_uses    [MAX_ROOMS];
    logic [ROOM_COUNT_W-1:0] rooms_cfg;

    // Rooms expected to be reported, oldest first.
    logic [ROOM_W-1:0] pending_room [$];

    int fail_cnt     = 0;
    int items_sent   = 0;
    int hold_reqs    = 0;
    bit sender_calm  = 1'b0;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    function automatic void clear_rooms();
        for (int i = 0; i < MAX_ROOMS; i++)
        begin
            room_free_at[i] = '0;
            room_uses[i]    = '0;
        end
    endfunction

    // Books one meeting into the predictor. A free room (its end at or before
    // the requested start) is taken lowest index first; otherwise the meeting
    // slides onto the earliest-ending room and keeps its length. On a closing
    // request the busiest room in use is reported and the job is cleared.
    function automatic void schedule_meeting(input logic [TIME_W-1:0] st,
                                             input logic [TIME_W-1:0] en,
                                             input logic lst,
                                             output bit has_res,
                                             output logic [ROOM_W-1:0] room);
        int n;
        int pick;
        int busiest;
        bit found;
        logic [END_W-1:0] dur;
        logic [END_W:0]   sum;
        n = int'(rooms_cfg);
        if (n == 0)
            n = 1;
        if (n > MAX_ROOMS)
            n = MAX_ROOMS;
        found = 1'b0;
        pick  = 0;
        for (int i = 0; i < n; i++)
        begin
            if (!found && room_free_at[i] <= {{(END_W-TIME_W){1'b0}}, st})
            begin
                pick  = i;
                found = 1'b1;
            end
        end
        if (found)
            room_free_at[pick] = {{(END_W-TIME_W){1'b0}}, en};
        else
        begin
            dur = (en > st) ? {{(END_W-TIME_W){1'b0}}, en - st} : '0;
            for (int i = 1; i < n; i++)
            begin
                if (room_free_at[i] < room_free_at[pick])
                    pick = i;
            end
            sum = {1'b0, room_free_at[pick]} + {1'b0, dur};
            room_free_at[pick] = sum[END_W] ? END_MAX : sum[END_W-1:0];
        end
        if (room_uses[pick] != CNT_MAX)
            room_uses[pick] = room_uses[pick] + 1'b1;
        has_res = lst;
        room    = '0;
        if (lst)
        begin
            busiest = 0;
            for (int i = 1; i < n; i++)
            begin
                if (room_uses[i] > room_uses[busiest])
                    busiest = i;
            end
            room = busiest[ROOM_W-1:0];
            clear_rooms();
        end
    endfunction

    // Idle lengths from three bands of growing length: the shortest most often, the longest least often.
    function automatic int idle_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return $urandom_range(1, 3);
        else if (sel < 93)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (sender_calm || $urandom_range(0, 99) < 45)
            return 0;
        return idle_len();
    endfunction

    function automatic logic [ROOM_COUNT_W-1:0] pick_room_count();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return ROOM_COUNT_W'($urandom_range(17, 31));
            4, 5, 6: return ROOM_COUNT_W'($urandom_range(1, 8));
            default: return ROOM_COUNT_W'($urandom_range(1, 16));
        endcase
    endfunction

    // Offers one request after a random gap and waits for its transfer. The
    // valid is only lowered when a gap is taken, so that a back-to-back
    // request never sees valid fall and rise within one time step.
    task automatic offer_meeting(input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] en,
                                 input logic lst, input logic known,
                                 input logic [ROOM_W-1:0] known_room);
        int gap;
        bit has_res;
        logic [ROOM_W-1:0] room;
        gap = sender_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.start_time <= st;
        req_ch.end_time   <= en;
        req_ch.last       <= lst;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        schedule_meeting(st, en, lst, has_res, room);
        if (has_res)
            pending_room.push_back(known ? known_room : room);
        items_sent++;
    endtask

    // Brings the block to rest: no request on offer, every expected result
    // collected, and enough cycles for a request without a result to finish.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (pending_room.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_room_count(input logic [ROOM_COUNT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        rooms_cfg = val;
        cfg_we    <= 1'b0;
    endtask

    // One job of random meetings closed by a last request. Starts mostly climb
    // in small steps so that rooms overlap and meetings get delayed; a few
    // starts step backwards and a few ends fall at or before the start.
    task automatic random_job(input int len);
        logic [TIME_W-1:0] st;
        logic [TIME_W-1:0] en;
        int sel;
        st = '0;
        for (int k = 0; k < len; k++)
        begin
            sel = $urandom_range(0, 99);
            if (k == 0)
            begin
                if (sel < 40)
                    st = $urandom_range(0, 1000);
                else if (sel < 70)
                    st = $urandom;
                else if (sel < 90)
                    st = 32'hFFFF_FF00 | $urandom_range(0, 255);
                else
                    st = '0;
            end
            else if (sel < 70)
                st = sat_add(st, $urandom_range(0, 15));
            else if (sel < 90)
                st = sat_add(st, $urandom_range(16, 500));
            else if (sel < 95)
                st = sat_add(st, $urandom);
            else
                st = st - $urandom_range(1, 50);
            sel = $urandom_range(0, 99);
            if (sel < 85)
                en = sat_add(st, $urandom_range(1, 60));
            else if (sel < 90)
                en = $urandom;
            else if (sel < 95)
                en = st;
            else
                en = st - $urandom_range(1, 100);
            // Occasionally change the room count in the middle of a job.
            if (k > 0 && k < len - 1 && $urandom_range(0, 99) < 3)
            begin
                settle_block();
                set_room_count(pick_room_count());
            end
            offer_meeting(st, en, (k == len - 1), 1'b0, '0);
        end
    endtask

    // Receiver: ready mostly high with random stalls, calm stretches without
    // any stall, and a long hold-off whenever the stimulus asks for one.
    initial
    begin : res_ready_drv
        int stall_left;
        int hold_left;
        int calm_left;
        int hold_seen;
        int sel;
        stall_left = 0;
        hold_left  = 0;
        calm_left  = 0;
        hold_seen  = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 2)
                        calm_left = $urandom_range(100, 400);
                    else if (sel < 40)
                        stall_left = idle_len();
                end
            end
        end
    end

    // Scoreboard: every result transfer is matched against the oldest expected room.
    always @(posedge clk)
    begin : result_check
        logic [ROOM_W-1:0] want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (pending_room.size() == 0)
            begin
                $error("most_booked_room: expected nothing, actual %0d",
                       res_ch.most_booked_room);
                fail_cnt++;
            end
            else
            begin
                want = pending_room.pop_front();
                if (res_ch.most_booked_room !== want)
                begin
                    $error("most_booked_room: expected %0d, actual %0d",
                           want, res_ch.most_booked_room);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        bit squeeze_done;
        int sel;
        int len;
        squeeze_done = 1'b0;

        // Every input known from time zero; reset held low at first, then released.
        rst_n             = 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.start_time <= '0;
        req_ch.end_time   <= '0;
        req_ch.last       <= 1'b0;
        clear_rooms();
        rooms_cfg = ROOM_COUNT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (int r = 0; r < PLAN_LEN; r++)
        begin
            if (PLAN[r].cfg_set)
            begin
                settle_block();
                set_room_count(PLAN[r].cfg_val);
            end
            offer_meeting(PLAN[r].start_time, PLAN[r].end_time, PLAN[r].last,
                          PLAN[r].known_res, PLAN[r].room);
        end

        // One room, a long run of the longest meetings: each after the first is delayed
        // onto the same room until its end time saturates at the top of its range.
        settle_block();
        set_room_count(5'd1);
        for (int i = 0; i < 280; i++)
            offer_meeting('0, 32'hFFFF_FFFF, (i == 279), 1'b0, '0);

        while (items_sent < PLAN_LEN + ITEM_TARGET)
        begin
            // Halfway through, hold off the receiver while closing requests keep
            // coming back to back, so results pile up and the input stalls.
            if (!squeeze_done && items_sent > PLAN_LEN + ITEM_TARGET / 2)
            begin
                settle_block();
                set_room_count(5'd2);
                sender_calm = 1'b1;
                hold_reqs <= hold_reqs + 1;
                for (int j = 0; j < 12; j++)
                    random_job($urandom_range(1, 2));
                squeeze_done = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                settle_block();
                set_room_count(pick_room_count());
            end
            sender_calm = ($urandom_range(0, 7) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 70)
                len = $urandom_range(1, 8);
            else if (sel < 95)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(25, 60);
            random_job(len);
        end

        // Collect the outstanding results, then allow a little extra time for
        // anything spurious to show up before judging the run.
        req_ch.valid <= 1'b0;
        while (pending_room.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
